FILE: rtl/core/lqe_pkg.sv
// shared types and constants for the line to quad expansion block
package lqe_pkg;

	localparam int COORD_W   = 24;
	localparam int POS_W     = 25;
	localparam int COLOR_W   = 8;
	localparam int IDX_OUT_W = 24;
	localparam int CFG_W     = 16;
	localparam int REC_W     = 4;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THICK  = 2'd2;

	// word kinds
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_INDEX  = 1'b1;

	// record numbering inside one segment
	localparam logic [REC_W-1:0] FIRST_INDEX_REC = 4'd4;
	localparam logic [REC_W-1:0] LAST_REC        = 4'd9;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [CFG_W-1:0] thick;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             check;
		logic             shift;
		logic             square;
		logic             root_go;
		logic             offset;
		logic             emit;
		logic [REC_W-1:0] rec;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic norm_done;
		logic root_done;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/lqe_root.sv
// bit-serial rounded unit component a / sqrt(s) with one shared multiplier
module lqe_root import lqe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [14:0] a,
	input  logic [30:0] s,
	output logic        done,
	output logic [15:0] u
);

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_SQA  = 3'd1;
	localparam logic [2:0] R_LA   = 3'd2;
	localparam logic [2:0] R_SQ   = 3'd3;
	localparam logic [2:0] R_PR   = 3'd4;
	localparam logic [2:0] R_CMP  = 3'd5;
	localparam logic [2:0] R_DONE = 3'd6;

	logic [2:0]  ph_q;
	logic [14:0] a_q;
	logic [30:0] s_q;
	logic [29:0] a2_q;
	logic [15:0] u_q;
	logic [3:0]  bit_q;
	logic        fin_q;
	logic [63:0] mul_q;

	logic [15:0] cand;
	logic [31:0] opa, opb;
	logic [61:0] rhs;
	logic        ok;
	logic [15:0] u_nx;

	// trial value: next bit set, or 2u+1 for the rounding test
	assign cand = fin_q ? {u_q[14:0], 1'b1} : (u_q | (16'd1 << bit_q));

	always_comb begin
		case (ph_q)
			R_SQA: begin
				opa = {17'd0, a_q};
				opb = {17'd0, a_q};
			end
			R_SQ: begin
				opa = {16'd0, cand};
				opb = {16'd0, cand};
			end
			R_PR: begin
				opa = mul_q[31:0];
				opb = {1'b0, s_q};
			end
			default: begin
				opa = 32'd0;
				opb = 32'd0;
			end
		endcase
	end

	// rounding test compares against 4x the numerator
	assign rhs  = fin_q ? {a2_q, 32'd0} : {2'd0, a2_q, 30'd0};
	assign ok   = mul_q <= 64'(rhs);
	assign u_nx = ok ? cand : u_q;

	always_ff @(posedge clk) begin
		mul_q <= opa * opb;
		if (start) begin
			a_q <= a;
			s_q <= s;
		end
		if (ph_q == R_LA)
			a2_q <= mul_q[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= R_IDLE;
			u_q   <= 16'd0;
			bit_q <= 4'd15;
			fin_q <= 1'b0;
		end else begin
			case (ph_q)
				R_IDLE, R_DONE: begin
					if (start) begin
						u_q   <= 16'd0;
						bit_q <= 4'd15;
						fin_q <= 1'b0;
						ph_q  <= R_SQA;
					end
				end
				R_SQA: ph_q <= R_LA;
				R_LA:  ph_q <= R_SQ;
				R_SQ:  ph_q <= R_PR;
				R_PR:  ph_q <= R_CMP;
				R_CMP: begin
					if (fin_q) begin
						if (ok)
							u_q <= u_q + 16'd1;
						ph_q <= R_DONE;
					end else begin
						u_q <= u_nx;
						if (bit_q == 4'd0) begin
							// a full unit vector never rounds up
							if (u_nx == 16'h8000) begin
								ph_q <= R_DONE;
							end else begin
								fin_q <= 1'b1;
								ph_q  <= R_SQ;
							end
						end else begin
							bit_q <= bit_q - 4'd1;
							ph_q  <= R_SQ;
						end
					end
				end
				default: ph_q <= R_IDLE;
			endcase
		end
	end

	assign done = (ph_q == R_DONE);
	assign u    = u_q;

	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !done) else $error("root done right after start");

endmodule

FILE: rtl/core/lqe_dp.sv
// datapath: reject test, normal scaling, vertex and index word formation
module lqe_dp import lqe_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int INDEX_BITS      = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic signed [COORD_W-1:0]   start_x,
	input  logic signed [COORD_W-1:0]   start_y,
	input  logic signed [COORD_W-1:0]   end_x,
	input  logic signed [COORD_W-1:0]   end_y,
	input  logic [COLOR_W-1:0]          start_red,
	input  logic [COLOR_W-1:0]          start_green,
	input  logic [COLOR_W-1:0]          start_blue,
	input  logic [COLOR_W-1:0]          end_red,
	input  logic [COLOR_W-1:0]          end_green,
	input  logic [COLOR_W-1:0]          end_blue,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        result_kind,
	output logic signed [POS_W-1:0]     pos_x,
	output logic signed [POS_W-1:0]     pos_y,
	output logic [COLOR_W-1:0]          red,
	output logic [COLOR_W-1:0]          green,
	output logic [COLOR_W-1:0]          blue,
	output logic                        tex_u,
	output logic                        tex_v,
	output logic [IDX_OUT_W-1:0]        index_value,
	output logic                        last
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int PW = 33 + F;
	localparam logic signed [24:0] BIAS = 25'((64'd1 << F) - 64'd1);
	localparam logic signed [24:0] HALF = 25'((64'd1 << F) >> 1);
	localparam longint unsigned THR = (64'd1 << (2 * F)) / 64'd100000000;

	// truncate toward zero to whole pixels
	function automatic logic signed [24:0] whole(input logic signed [24:0] v);
		whole = v[24] ? ((v + BIAS) >>> F) : (v >>> F);
	endfunction

	function automatic logic [23:0] off_mag(input logic [15:0] uu, input logic [15:0] t);
		logic [31:0]   ut;
		logic [PW-1:0] p;
		ut = 32'(uu) * 32'(t);
		p  = (PW'(ut) << F) + (PW'(1) << 23);
		off_mag = 24'(p >> 24);
	endfunction

	function automatic logic [POS_W-1:0] sat(input logic signed [26:0] v);
		if (v > 27'sd16777215)
			sat = 25'h0FFFFFF;
		else if (v < -27'sd16777216)
			sat = 25'h1000000;
		else
			sat = v[24:0];
	endfunction

	function automatic logic [1:0] tri_corner(input logic [REC_W-1:0] r);
		case (r)
			4'd4:    tri_corner = 2'd0;
			4'd5:    tri_corner = 2'd1;
			4'd6:    tri_corner = 2'd2;
			4'd7:    tri_corner = 2'd2;
			4'd8:    tri_corner = 2'd1;
			4'd9:    tri_corner = 2'd3;
			default: tri_corner = 2'd0;
		endcase
	endfunction

	logic signed [24:0] sx_q, sy_q, ex_q, ey_q;
	logic [COLOR_W-1:0] sr_q, sg_q, sb_q, er_q, eg_q, eb_q;
	logic [24:0]        ax_q, ay_q;
	logic               dx_neg_q, dy_pos_q, reject_q;
	logic [30:0]        s_q;
	logic signed [24:0] ox_q, oy_q;
	logic [INDEX_BITS-1:0] vtot_q;

	logic               out_valid_q;
	logic               kind_q, tu_q, tv_q, last_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [COLOR_W-1:0] r_q, g_q, b_q;
	logic [IDX_OUT_W-1:0] idx_q;

	// reject and same-pixel test
	logic signed [33:0] wl, hl, sx34, sy34, ex34, ey34;
	logic               reject, same;
	logic signed [24:0] ex_adj;
	logic signed [25:0] dx, dy;
	logic [6:0]         sqx, sqy;
	logic [7:0]         sq_sum;
	logic               tiny;
	logic [15:0]        ux, uy;
	logic               ux_done, uy_done;
	logic [23:0]        offx, offy;

	assign wl   = $signed(34'(cfg.width)) <<< F;
	assign hl   = $signed(34'(cfg.height)) <<< F;
	assign sx34 = 34'(sx_q);
	assign sy34 = 34'(sy_q);
	assign ex34 = 34'(ex_q);
	assign ey34 = 34'(ey_q);

	assign reject = (sx34 < 0 && ex34 < 0) || (sx34 > wl && ex34 > wl) ||
		(sy34 < 0 && ey34 < 0) || (sy34 > hl && ey34 > hl);
	assign same   = (whole(sx_q) == whole(ex_q)) && (whole(sy_q) == whole(ey_q));
	assign ex_adj = same ? (sx_q + HALF) : ex_q;
	assign dx     = 26'(ex_adj) - 26'(sx_q);
	assign dy     = 26'(ey_q) - 26'(sy_q);

	// only very short segments can fall under the length threshold
	assign sqx    = {4'd0, ax_q[2:0]} * {4'd0, ax_q[2:0]};
	assign sqy    = {4'd0, ay_q[2:0]} * {4'd0, ay_q[2:0]};
	assign sq_sum = {1'b0, sqx} + {1'b0, sqy};
	assign tiny   = !(|ax_q[24:3]) && !(|ay_q[24:3]) && (64'(sq_sum) <= THR);

	lqe_root u_root_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.root_go),
		.a(ax_q[14:0]), .s(s_q), .done(ux_done), .u(ux)
	);

	lqe_root u_root_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.root_go),
		.a(ay_q[14:0]), .s(s_q), .done(uy_done), .u(uy)
	);

	assign offx = off_mag(ux, cfg.thick);
	assign offy = off_mag(uy, cfg.thick);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= 25'(start_x);
			sy_q <= 25'(start_y);
			ex_q <= 25'(end_x);
			ey_q <= 25'(end_y);
			sr_q <= start_red;
			sg_q <= start_green;
			sb_q <= start_blue;
			er_q <= end_red;
			eg_q <= end_green;
			eb_q <= end_blue;
		end
		if (cmd.check) begin
			ex_q     <= ex_adj;
			ax_q     <= 25'(dx[25] ? -dx : dx);
			ay_q     <= 25'(dy[25] ? -dy : dy);
			dx_neg_q <= dx[25];
			dy_pos_q <= !dy[25] && (dy != 26'sd0);
			reject_q <= reject;
		end
		if (cmd.shift) begin
			ax_q <= ax_q >> 1;
			ay_q <= ay_q >> 1;
		end
		if (cmd.square)
			s_q <= {1'b0, {15'd0, ax_q[14:0]} * {15'd0, ax_q[14:0]}} +
				{1'b0, {15'd0, ay_q[14:0]} * {15'd0, ay_q[14:0]}};
		if (cmd.offset) begin
			ox_q <= dy_pos_q ? -$signed({1'b0, offy}) : $signed({1'b0, offy});
			oy_q <= dx_neg_q ? -$signed({1'b0, offx}) : $signed({1'b0, offx});
		end
	end

	// word formation
	logic                  is_vtx, at_end, plus;
	logic signed [26:0]    bx, by, px, py;
	logic [INDEX_BITS-1:0] isum;

	assign is_vtx = cmd.rec < FIRST_INDEX_REC;
	assign at_end = cmd.rec[1];
	assign plus   = cmd.rec[0];
	assign bx     = 27'(at_end ? ex_q : sx_q);
	assign by     = 27'(at_end ? ey_q : sy_q);
	assign px     = plus ? bx + 27'(ox_q) : bx - 27'(ox_q);
	assign py     = plus ? by + 27'(oy_q) : by - 27'(oy_q);
	assign isum   = vtot_q + INDEX_BITS'(tri_corner(cmd.rec));

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (is_vtx) begin
				kind_q <= KIND_VERTEX;
				px_q   <= sat(px);
				py_q   <= sat(py);
				r_q    <= at_end ? er_q : sr_q;
				g_q    <= at_end ? eg_q : sg_q;
				b_q    <= at_end ? eb_q : sb_q;
				tu_q   <= at_end;
				tv_q   <= plus;
				idx_q  <= '0;
				last_q <= 1'b0;
			end else begin
				kind_q <= KIND_INDEX;
				px_q   <= '0;
				py_q   <= '0;
				r_q    <= '0;
				g_q    <= '0;
				b_q    <= '0;
				tu_q   <= 1'b0;
				tv_q   <= 1'b0;
				idx_q  <= IDX_OUT_W'(isum);
				last_q <= (cmd.rec == LAST_REC);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			vtot_q      <= '0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.emit && cmd.rec == LAST_REC)
				vtot_q <= vtot_q + INDEX_BITS'(4);
		end
	end

	assign stat.skip      = reject_q || tiny;
	assign stat.norm_done = !(|(ax_q[24:15] | ay_q[24:15]));
	assign stat.root_done = ux_done && uy_done;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign pos_x       = px_q;
	assign pos_y       = py_q;
	assign red         = r_q;
	assign green       = g_q;
	assign blue        = b_q;
	assign tex_u       = tu_q;
	assign tex_v       = tv_q;
	assign index_value = idx_q;
	assign last        = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready)) else $error("pending word overwritten");

	a_last_is_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (kind_q == KIND_INDEX)) else $error("last on vertex word");

endmodule

FILE: rtl/core/lqe_ctrl.sv
// controller state machine sequencing one segment through the datapath
module lqe_ctrl import lqe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_EVAL  = 4'd2;
	localparam logic [3:0] ST_NORM  = 4'd3;
	localparam logic [3:0] ST_SQR   = 4'd4;
	localparam logic [3:0] ST_RGO   = 4'd5;
	localparam logic [3:0] ST_RWAIT = 4'd6;
	localparam logic [3:0] ST_OFFS  = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [REC_W-1:0] rec_q, rec_d;

	always_comb begin
		state_d     = state_q;
		rec_d       = rec_q;
		cmd         = '0;
		cmd.rec     = rec_q;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_EVAL;
			end
			ST_EVAL: state_d = stat.skip ? ST_IDLE : ST_NORM;
			ST_NORM: begin
				if (stat.norm_done)
					state_d = ST_SQR;
				else
					cmd.shift = 1'b1;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_d    = ST_RGO;
			end
			ST_RGO: begin
				cmd.root_go = 1'b1;
				state_d     = ST_RWAIT;
			end
			ST_RWAIT: if (stat.root_done) state_d = ST_OFFS;
			ST_OFFS: begin
				cmd.offset = 1'b1;
				rec_d      = '0;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (rec_q == LAST_REC)
						state_d = ST_IDLE;
					else
						rec_d = rec_q + 4'd1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rec_q   <= '0;
		end else begin
			state_q <= state_d;
			rec_q   <= rec_d;
		end
	end

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cmd.emit && rec_q == LAST_REC) |=> (state_q == ST_IDLE))
		else $error("no return to idle after last word");

endmodule

FILE: rtl/core/line_to_quad_expansion.sv
// top level of the line segment to quad triangle setup block
//
// one input word is a segment: two signed endpoints with COORD_FRAC_BITS
// fraction bits and an rgb color per end, taken on in_valid && in_ready
// a segment wholly outside the window, or shorter than 1e-4 pixel, gives
// no output words; otherwise ten output words follow on out_valid/out_ready:
// four vertex words (start minus, start plus, end minus, end plus) and then
// six index words for triangles 0,1,2 and 2,1,3, the sixth with last set
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 width, 1 height, 2 thickness); other indexes are dropped
// sequence: a rejected segment is loaded, checked, evaluated and dropped;
// an emitted one runs the normalizing shifts, the bit-serial root/divide
// unit (a square, a product with s and a compare per result bit, x and y
// lanes side by side), then one output word per cycle while not stalled
// in_ready is high only while the controller is idle; it may already be
// high while the final output word still waits in the output register
// a stalled receiver holds the output register and freezes the sequence
// reset restores the default window 1920x1080, thickness one pixel and
// clears the running vertex count
module line_to_quad_expansion import lqe_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int INDEX_BITS      = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0]        start_red,
	input  logic [COLOR_W-1:0]        start_green,
	input  logic [COLOR_W-1:0]        start_blue,
	input  logic [COLOR_W-1:0]        end_red,
	input  logic [COLOR_W-1:0]        end_green,
	input  logic [COLOR_W-1:0]        end_blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      result_kind,
	output logic signed [POS_W-1:0]   pos_x,
	output logic signed [POS_W-1:0]   pos_y,
	output logic [COLOR_W-1:0]        red,
	output logic [COLOR_W-1:0]        green,
	output logic [COLOR_W-1:0]        blue,
	output logic                      tex_u,
	output logic                      tex_v,
	output logic [IDX_OUT_W-1:0]      index_value,
	output logic                      last
);

	// configuration registers
	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 16'd1920;
			cfg_q.height <= 16'd1080;
			cfg_q.thick  <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_THICK:  cfg_q.thick  <= cfg_data;
				default: ; // unused index, write ignored
			endcase
		end
	end

	// sequencing
	lqe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	// arithmetic and output register
	lqe_dp #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .stat(stat),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.start_red(start_red), .start_green(start_green), .start_blue(start_blue),
		.end_red(end_red), .end_green(end_green), .end_blue(end_blue),
		.out_ready(out_ready), .out_valid(out_valid),
		.result_kind(result_kind), .pos_x(pos_x), .pos_y(pos_y),
		.red(red), .green(green), .blue(blue), .tex_u(tex_u), .tex_v(tex_v),
		.index_value(index_value), .last(last)
	);

endmodule

FILE: bench/lqe_checker.sv
// channel monitor, segment expansion predictor and word comparator
`timescale 1ns / 100ps

module lqe_checker import lqe_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0]        start_red,
	input  logic [COLOR_W-1:0]        start_green,
	input  logic [COLOR_W-1:0]        start_blue,
	input  logic [COLOR_W-1:0]        end_red,
	input  logic [COLOR_W-1:0]        end_green,
	input  logic [COLOR_W-1:0]        end_blue,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      result_kind,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic [COLOR_W-1:0]        red,
	input  logic [COLOR_W-1:0]        green,
	input  logic [COLOR_W-1:0]        blue,
	input  logic                      tex_u,
	input  logic                      tex_v,
	input  logic [IDX_OUT_W-1:0]      index_value,
	input  logic                      last,
	output int                        failures,
	output int                        pending,
	output int                        words_seen
);

	localparam int FRAC = 8;
	localparam longint SHORT_LIMIT = (64'd1 << (2 * FRAC)) / 100000000;
	localparam longint POS_HI = 16777215;
	localparam longint POS_LO = -16777216;

	typedef struct packed {
		logic                    kind;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [COLOR_W-1:0]      r;
		logic [COLOR_W-1:0]      g;
		logic [COLOR_W-1:0]      b;
		logic                    u;
		logic                    v;
		logic [IDX_OUT_W-1:0]    idx;
		logic                    lst;
	} quad_word_t;

	quad_word_t       quad_words_q[$];
	logic [CFG_W-1:0] win_w, win_h, thick;
	logic [23:0]      vertex_total;

	function automatic longint whole_pixel(longint v);
		return (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
		if (v > POS_HI) v = POS_HI;
		if (v < POS_LO) v = POS_LO;
		return v[POS_W-1:0];
	endfunction

	// a / sqrt(s) with 15 fraction bits, rounded to nearest
	function automatic logic [127:0] unit_len(logic [127:0] a, logic [127:0] s);
		logic [127:0] num, u, c;
		num = (a * a) << 30;
		u = 0;
		for (int b = 15; b >= 0; b--) begin
			c = u | (128'd1 << b);
			if (c * c * s <= num) u = c;
		end
		if ((2 * u + 1) * (2 * u + 1) * s <= 4 * num) u++;
		return u;
	endfunction

	function automatic longint half_width(logic [127:0] u);
		logic [127:0] p;
		p = (u * thick) << FRAC;
		return longint'((p + (128'd1 << 23)) >> 24);
	endfunction

	function automatic void expand_segment();
		longint sx, sy, ex, ey, wl, hl, dx, dy, ox, oy, offx, offy;
		longint unsigned ax, ay, s;
		int k;
		int corner[6];
		quad_word_t w;
		logic [COLOR_W-1:0] cs[3], ce[3];
		sx = longint'(start_x); sy = longint'(start_y);
		ex = longint'(end_x); ey = longint'(end_y);
		cs = '{start_red, start_green, start_blue};
		ce = '{end_red, end_green, end_blue};
		corner = '{0, 1, 2, 2, 1, 3};
		wl = longint'(win_w) << FRAC;
		hl = longint'(win_h) << FRAC;
		// off-screen reject
		if ((sx < 0 && ex < 0) || (sx > wl && ex > wl) ||
		    (sy < 0 && ey < 0) || (sy > hl && ey > hl))
			return;
		// both ends in one pixel: stretch by half a pixel in x
		if (whole_pixel(sx) == whole_pixel(ex) && whole_pixel(sy) == whole_pixel(ey))
			ex = sx + (1 << (FRAC - 1));
		dx = ex - sx;
		dy = ey - sy;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		s = ax * ax + ay * ay;
		if (s <= SHORT_LIMIT) return;
		k = 0;
		while ((ax >> k) >= 32768 || (ay >> k) >= 32768) k++;
		ax >>= k;
		ay >>= k;
		s = ax * ax + ay * ay;
		offx = half_width(unit_len(128'(ax), 128'(s)));
		offy = half_width(unit_len(128'(ay), 128'(s)));
		ox = (dy > 0) ? -offy : offy;
		oy = (dx >= 0) ? offx : -offx;
		for (int v = 0; v < 4; v++) begin
			w = '0;
			w.kind = KIND_VERTEX;
			w.u = (v >= 2);
			w.v = v[0];
			w.px = clamp_pos(((v >= 2) ? ex : sx) + (v[0] ? ox : -ox));
			w.py = clamp_pos(((v >= 2) ? ey : sy) + (v[0] ? oy : -oy));
			w.r = (v >= 2) ? ce[0] : cs[0];
			w.g = (v >= 2) ? ce[1] : cs[1];
			w.b = (v >= 2) ? ce[2] : cs[2];
			quad_words_q.push_back(w);
		end
		for (int j = 0; j < 6; j++) begin
			w = '0;
			w.kind = KIND_INDEX;
			w.idx = IDX_OUT_W'(vertex_total + 24'(corner[j]));
			w.lst = (j == 5);
			quad_words_q.push_back(w);
		end
		vertex_total = vertex_total + 24'd4;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		quad_word_t e;
		if (!arst_n) begin
			win_w = 16'd1920;
			win_h = 16'd1080;
			thick = 16'd256;
			vertex_total = '0;
			quad_words_q.delete();
			failures = 0;
			words_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  win_w = cfg_data;
					REG_HEIGHT: win_h = cfg_data;
					REG_THICK:  thick = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				words_seen++;
				if (quad_words_q.size() == 0) begin
					$error("output word with nothing expected");
					failures++;
				end else begin
					e = quad_words_q.pop_front();
					check_field("result_kind", e.kind, result_kind);
					check_field("pos_x", e.px, pos_x);
					check_field("pos_y", e.py, pos_y);
					check_field("red", e.r, red);
					check_field("green", e.g, green);
					check_field("blue", e.b, blue);
					check_field("tex_u", e.u, tex_u);
					check_field("tex_v", e.v, tex_v);
					check_field("index_value", e.idx, index_value);
					check_field("last", e.lst, last);
				end
			end
			if (in_valid && in_ready) expand_segment();
		end
		pending = quad_words_q.size();
	end

endmodule

FILE: bench/tb_top.sv
// stimulus, reset, clocking and verdict for the line to quad expansion block
`timescale 1ns / 100ps

module tb_top;
	import lqe_pkg::*;

	localparam logic [1:0] REG_NONE = 2'd3;   // beyond the register list, must be dropped
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 100;

	// segment flavors for the random part
	localparam int SEG_VISIBLE = 0;
	localparam int SEG_WILD    = 1;
	localparam int SEG_SHORT   = 2;
	localparam int SEG_OUTSIDE = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [COLOR_W-1:0] start_red = '0, start_green = '0, start_blue = '0;
	logic [COLOR_W-1:0] end_red = '0, end_green = '0, end_blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic [COLOR_W-1:0] red, green, blue;
	logic tex_u, tex_v;
	logic [IDX_OUT_W-1:0] index_value;
	logic last;

	int failures, pending, words_seen;
	int segments_sent = 0;
	int stall_cycles = 0;
	bit quiet = 1'b0;        // no idling on either side while set
	bit hold_off_req = 1'b0; // asks the receiver for one long stall
	// current window, kept here to aim random segments at it
	int win_w = 1920, win_h = 1080;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_to_quad_expansion DUT (.*);

	lqe_checker u_checker (.*);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_off_req) begin
			out_ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			hold_off_req = 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 29);
		end
	end

	// watchdog: cycles in which no word moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("** line_to_quad_expansion: FAILED **");
			$finish;
		end
	end

	// three back-to-back register writes, plus one to an unused index
	task automatic write_window(int w, int h, int t);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_index <= REG_THICK;
		cfg_data <= CFG_W'(t);
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		win_w = w;
		win_h = h;
		@(posedge clk);
	endtask

	// holds the word until accepted, then maybe leaves a gap
	task automatic send_segment(int sx, int sy, int ex, int ey,
			int sr, int sg, int sb, int er, int eg, int eb);
		int gap;
		in_valid <= 1'b1;
		start_x <= COORD_W'(sx); start_y <= COORD_W'(sy);
		end_x <= COORD_W'(ex); end_y <= COORD_W'(ey);
		start_red <= COLOR_W'(sr); start_green <= COLOR_W'(sg);
		start_blue <= COLOR_W'(sb);
		end_red <= COLOR_W'(er); end_green <= COLOR_W'(eg); end_blue <= COLOR_W'(eb);
		do @(posedge clk); while (!in_ready);
		segments_sent++;
		if (!quiet && $urandom_range(99) < 29) begin
			gap = $urandom_range(12, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_plain(int sx, int sy, int ex, int ey);
		send_segment(sx, sy, ex, ey, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255));
	endtask

	function automatic int clamp_coord(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return int'(v);
	endfunction

	// one random segment aimed at the current window
	task automatic send_random;
		int pick, flavor, sx, sy, ex, ey, xr, yr;
		longint wl, hl;
		pick = $urandom_range(99);
		flavor = (pick < 60) ? SEG_VISIBLE : (pick < 75) ? SEG_WILD :
			(pick < 90) ? SEG_SHORT : SEG_OUTSIDE;
		wl = longint'(win_w) << 8;
		hl = longint'(win_h) << 8;
		xr = clamp_coord(wl + 1024);
		yr = clamp_coord(hl + 1024);
		sx = clamp_coord(longint'($urandom_range(xr)) - 512);
		sy = clamp_coord(longint'($urandom_range(yr)) - 512);
		ex = clamp_coord(longint'($urandom_range(xr)) - 512);
		ey = clamp_coord(longint'($urandom_range(yr)) - 512);
		case (flavor)
			SEG_WILD: begin
				sx = $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
				sy = $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
				ex = $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
				ey = $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
			end
			SEG_SHORT: begin
				ex = clamp_coord(longint'(sx) + $urandom_range(600) - 300);
				ey = clamp_coord(longint'(sy) + $urandom_range(600) - 300);
			end
			SEG_OUTSIDE: begin
				case ($urandom_range(3))
					0: begin sx = -1 - $urandom_range(5000); ex = -1 - $urandom_range(5000); end
					1: begin
						sx = clamp_coord(wl + 1 + $urandom_range(5000));
						ex = clamp_coord(wl + 1 + $urandom_range(5000));
					end
					2: begin sy = -1 - $urandom_range(5000); ey = -1 - $urandom_range(5000); end
					default: begin
						sy = clamp_coord(hl + 1 + $urandom_range(5000));
						ey = clamp_coord(hl + 1 + $urandom_range(5000));
					end
				endcase
			end
			default: ;
		endcase
		send_plain(sx, sy, ex, ey);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed segments under the reset window 1920x1080, one pixel wide
		quiet = 1'b1;
		send_plain(1000, 1000, 20000, 1000);          // horizontal
		send_plain(5000, 1000, 5000, 90000);          // vertical, dy up
		send_plain(5000, 90000, 5000, 1000);          // vertical, dy down
		send_plain(90000, 90000, 3000, 4000);         // both deltas negative
		send_plain(3000, 90000, 90000, 4000);         // dx up, dy down
		send_plain(2560, 2560, 2600, 2700);           // both ends in one pixel
		send_plain(-100, 50, 100, 60);                // one pixel across zero
		send_plain(-10, -10, -20, -30);               // just off the left
		send_plain(-500, 300, -1, 20000);             // left
		send_plain(491521, 300, 500000, 20000);       // right of the window
		send_plain(300, -5, 20000, -1);               // above
		send_plain(300, 276481, 20000, 300000);       // below
		send_plain(491520, 276480, 491520, 276480);   // on the far corner
		send_segment(-8388608, -8388608, 8388607, 8388607, 0, 0, 0, 255, 255, 255);
		send_segment(8388607, -8388608, -8388608, 8388607, 255, 255, 255, 0, 0, 0);
		send_plain(0, 0, 8388607, 1);                 // long, shifted before the root
		send_plain(0, 8388607, 8388607, 0);
		send_plain(8388607, 8388607, 8388607, 8388607);
		send_plain(0, 0, 0, 0);
		send_plain(100, 100, 101, 100);               // tiny, same pixel
		quiet = 1'b0;
		drain();

		// empty window, widest line: a long receiver hold-off midway
		write_window(0, 0, 65535);
		for (int i = 0; i < 80; i++) begin
			if (i == 20) hold_off_req = 1'b1;
			send_random();
		end
		drain();

		// largest window, zero thickness, no idling at all
		write_window(65535, 65535, 0);
		quiet = 1'b1;
		for (int i = 0; i < 80; i++) send_random();
		quiet = 1'b0;
		drain();

		// small window, thinnest nonzero line; the sender pauses until all is out
		write_window(640, 480, 1);
		for (int i = 0; i < 80; i++) begin
			if (i == 40) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
			end
			send_random();
		end
		drain();

		// back to the usual window with a random thickness
		write_window(1920, 1080, $urandom_range(2048, 1));
		for (int i = 0; i < 150; i++) send_random();
		drain();

		$display("ran %0d segments over five window/thickness settings, %0d output words",
			segments_sent, words_seen);
		$display("including a %0d-cycle receiver hold-off and a sender pause", HOLD_OFF_CYCLES);
		if (failures == 0)
			$display("** line_to_quad_expansion: PASSED **");
		else
			$display("** line_to_quad_expansion: FAILED **");
		$finish;
	end

endmodule
